// File: design/lce_pkg.sv
package lce_pkg;

  // Key codes seen on the serial receive side
  localparam logic [7:0] KEY_LIST = 8'h10;  // control-P
  localparam logic [7:0] KEY_KILL = 8'h15;  // control-U
  localparam logic [7:0] KEY_BS   = 8'h08;  // backspace
  localparam logic [7:0] KEY_DEL  = 8'h7F;  // delete
  localparam logic [7:0] KEY_EOF  = 8'h04;  // control-D
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_NUL  = 8'h00;

  // Command codes
  localparam logic CMD_TYPE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Echo kinds
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_CRLF  = 2'd2;
  localparam logic [1:0] ECHO_ERASE = 2'd3;

  // Read status codes
  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_DELIV = 2'd1;
  localparam logic [1:0] RS_EMPTY = 2'd2;
  localparam logic [1:0] RS_EOF   = 2'd3;

  localparam logic [7:0] ERASE_MAX = 8'd255;

  typedef struct packed {
    logic       command;
    logic [7:0] char_in;
    logic       read_first;
  } item_t;

  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic [1:0] read_status;
    logic [7:0] read_char;
    logic       line_done;
    logic       list_request;
    logic       dropped;
  } result_t;

endpackage

// File: design/lce_ram.sv
module lce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/lce_edit.sv
module lce_edit
  import lce_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         exec,
  input  item_t                        cur,
  input  logic [7:0]                   rd_data,
  output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
  output logic                         wr_en,
  output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
  output logic [7:0]                   wr_data,
  output result_t                      res
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int PW = $clog2(2 * BUF_DEPTH);
  localparam logic [PW:0]   MOD     = (PW + 1)'(2 * BUF_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(2 * BUF_DEPTH - 1);
  localparam logic [PW-1:0] ZERO_P  = '0;

  logic [PW-1:0] read_ptr, read_ptr_next;
  logic [PW-1:0] commit_ptr, commit_ptr_next;
  logic [PW-1:0] edit_ptr, edit_ptr_next;

  logic [PW-1:0] pending;
  logic [PW-1:0] used;
  logic [PW-1:0] edit_inc;
  logic [7:0]    ch;

  function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? (p - DEPTH_P) : p;
    return s[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_P) ? ZERO_P : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == ZERO_P) ? LAST_P : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] hi,
                                             input logic [PW-1:0] lo);
    logic [PW-1:0] d;
    d = hi - lo;
    if (hi < lo) begin
      d = d + MOD[PW-1:0];
    end
    return d;
  endfunction

  assign pending  = ptr_dist(edit_ptr, commit_ptr);
  assign used     = ptr_dist(edit_ptr, read_ptr);
  assign edit_inc = ptr_inc(edit_ptr);
  assign ch       = (cur.char_in == KEY_CR) ? KEY_LF : cur.char_in;

  // Present the read slot; the sequencer enables it when the item is taken
  assign rd_addr = slot(read_ptr);
  assign wr_addr = slot(edit_ptr);
  assign wr_data = ch;

  // Decode the item and work out pointer moves and the result
  always_comb begin
    res             = '0;
    wr_en           = 1'b0;
    read_ptr_next   = read_ptr;
    commit_ptr_next = commit_ptr;
    edit_ptr_next   = edit_ptr;
    if (cur.command == CMD_TYPE) begin
      priority if (cur.char_in == KEY_LIST) begin
        res.list_request = 1'b1;
      end else if (cur.char_in == KEY_KILL) begin
        if (pending != ZERO_P) begin
          res.echo_kind   = ECHO_ERASE;
          res.erase_count = (int'(pending) > 255) ? ERASE_MAX : 8'(pending);
          edit_ptr_next   = commit_ptr;
        end
      end else if (cur.char_in == KEY_BS || cur.char_in == KEY_DEL) begin
        if (pending != ZERO_P) begin
          res.echo_kind   = ECHO_ERASE;
          res.erase_count = 8'd1;
          edit_ptr_next   = ptr_dec(edit_ptr);
        end
      end else if (cur.char_in != KEY_NUL) begin
        if (used >= DEPTH_P) begin
          res.dropped = 1'b1;
        end else begin
          if (ch == KEY_LF) begin
            res.echo_kind = ECHO_CRLF;
          end else begin
            res.echo_kind = ECHO_CHAR;
            res.echo_char = ch;
          end
          wr_en         = exec;
          edit_ptr_next = edit_inc;
          // Commit on newline, end of file or a store that is now full
          if (ch == KEY_LF || ch == KEY_EOF || used == DEPTH_P - PW'(1)) begin
            commit_ptr_next = edit_inc;
          end
        end
      end else begin
        // Ignore a zero byte: keep the all-zero result
      end
    end else begin
      if (read_ptr == commit_ptr) begin
        res.read_status = RS_EMPTY;
      end else if (rd_data == KEY_EOF) begin
        res.read_status = RS_EOF;
        // Consume control-D only on the first byte of a read call
        if (cur.read_first) begin
          read_ptr_next = ptr_inc(read_ptr);
        end
      end else begin
        res.read_status = RS_DELIV;
        res.read_char   = rd_data;
        res.line_done   = (rd_data == KEY_LF);
        read_ptr_next   = ptr_inc(read_ptr);
      end
    end
  end

  // Advance the pointers once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr   <= '0;
      commit_ptr <= '0;
      edit_ptr   <= '0;
    end else if (exec) begin
      read_ptr   <= read_ptr_next;
      commit_ptr <= commit_ptr_next;
      edit_ptr   <= edit_ptr_next;
    end
  end

endmodule

// File: design/console_line_editor_buffer.sv
// Console line editor: canonical line discipline over a circular byte store.
// Command channel: drive item and raise start; the item is taken at a clock
// edge where start is high and busy is low. item.command selects a typed
// character (edit, echo, store, commit) or a one-byte read of committed text.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot hold it off, so it must sample result whenever done is high.
// Sequencing: result and done are registered at the end of the execute state
// (ST_EXEC) that follows the taking of an item. busy is high in ST_EXEC,
// the state entered on acceptance, so no new item is taken while one executes; a new
// item may be taken in the cycle that done shows the previous result.
// The read of the byte store is registered: the slot under the read pointer
// is read as the item is taken, and in ST_EXEC the item is decoded, the store
// is written and the pointers move.
// Reset (rst, synchronous) clears the three pointers, busy and done; store
// contents are left as they are, and are only read once written.
module console_line_editor_buffer
  import lce_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int AW = $clog2(BUF_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic           state;
  logic           accept;
  item_t          cur;
  result_t        res;
  logic [7:0]     rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;

  // Sequence: take an item, then execute it in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_EXEC);
      unique case (state)
        ST_IDLE: if (accept) state <= ST_EXEC;
        ST_EXEC: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the taken item and register the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    if (state == ST_EXEC) begin
      result <= res;
    end
  end

  lce_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lce_edit #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_edit (
    .clk     (clk),
    .rst     (rst),
    .exec    (state == ST_EXEC),
    .cur     (cur),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

endmodule

// File: design/lce_chk.sv
module lce_chk
  import lce_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input item_t   item,
  input result_t result
);

  // A taken item makes the block busy for the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item taken without busy");

  // Busy is followed in the next cycle by a result, with busy low again
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy not followed by a result");

  // A typed character never gives a read status
  a_type_no_read: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.command == CMD_TYPE |=> ##1
      (done && result.read_status == RS_NONE))
    else $error("typed item gave a read status");

  // A read never echoes and always reports a status
  a_read_no_echo: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.command == CMD_READ |=> ##1
      (done && result.echo_kind == ECHO_NONE && result.read_status != RS_NONE))
    else $error("read item gave an echo or no status");

endmodule

bind console_line_editor_buffer lce_chk u_chk (.*);
